// ===== rtl/pil_pkg.sv =====
// ----------------------------------------------------------------------------
// pil_pkg
// Types and constants shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pil_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;   // stored word width, at most the 32-bit port
  localparam int REQ_W      = 3;
  localparam int POS_W      = 5;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int CMP_W      = ((POS_W > FILL_W) ? POS_W : FILL_W) + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_RETRIEVE = 3'd2,
    REQ_REPLACE  = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_LOW  = 2'd2,
    CELL_FROM_HIGH = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] write_word;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_word;
    logic [1:0]        status;
    logic [CNT_W-1:0]  item_count;
    logic              is_full;
    logic              is_empty;
  } rsp_t;

  typedef struct packed {
    cell_op_t              op;
    logic [WORD_WIDTH-1:0] load_word;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pil_cell.sv =====
// ----------------------------------------------------------------------------
// pil_cell
// One list slot: holds, loads, or takes its lower or upper neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module pil_cell (
  input  wire logic                           clk,
  input  wire pil_pkg::cell_cmd_t             cmd,
  input  wire logic [pil_pkg::WORD_WIDTH-1:0] low_word,
  input  wire logic [pil_pkg::WORD_WIDTH-1:0] high_word,
  output logic      [pil_pkg::WORD_WIDTH-1:0] word
);

  logic [pil_pkg::WORD_WIDTH-1:0] word_next;

  always_comb begin
    case (cmd.op)
      pil_pkg::CELL_LOAD:      word_next = cmd.load_word;
      pil_pkg::CELL_FROM_LOW:  word_next = low_word;
      pil_pkg::CELL_FROM_HIGH: word_next = high_word;
      default:                 word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

// ===== rtl/positional_insert_delete_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top
// Bounded ordered list of words addressed by 1-based position, kept in a
// row of slot cells that shift together on a broadcast command.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       req  (pil_pkg::req_t)
//  result    done (one cycle)   rsp  (pil_pkg::rsp_t)
//
//  One item per cycle: every cell updates in the same cycle, busy stays low.
//  The result appears on rsp with done in the cycle after the item is taken.
//  Reset empties the list at once; slot contents are not cleared.
//  The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire pil_pkg::req_t req,
  output logic               done,
  output pil_pkg::rsp_t      rsp
);

  logic [pil_pkg::FILL_W-1:0]     fill_count;
  logic [pil_pkg::FILL_W-1:0]     fill_count_next;
  pil_pkg::rsp_t                  rsp_next;
  logic                           accept;
  logic [pil_pkg::CMP_W-1:0]      pos_x;
  logic [pil_pkg::CMP_W-1:0]      cnt_x;
  logic [pil_pkg::POS_W-1:0]      pos_m1;
  logic [pil_pkg::IDX_W-1:0]      idx;
  logic                           is_full_now;
  logic                           pos_ok;
  logic                           ins_pos_ok;
  logic                           do_insert;
  logic                           do_delete;
  logic                           do_replace;
  logic [pil_pkg::WORD_WIDTH-1:0] cell_word [pil_pkg::DEPTH];
  logic [pil_pkg::WORD_WIDTH-1:0] sel_word;
  logic [pil_pkg::WORD_WIDTH-1:0] wword;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign pos_x       = pil_pkg::CMP_W'(req.position);
  assign cnt_x       = pil_pkg::CMP_W'(fill_count);
  assign pos_m1      = req.position - pil_pkg::POS_W'(1);
  assign idx         = pil_pkg::IDX_W'(pos_m1);
  assign is_full_now = (cnt_x == pil_pkg::CMP_W'(pil_pkg::DEPTH));
  assign pos_ok      = (req.position != '0) && (pos_x <= cnt_x);
  assign ins_pos_ok  = (req.position != '0) && (pos_x <= cnt_x + pil_pkg::CMP_W'(1));
  assign sel_word    = cell_word[idx];
  assign wword       = req.write_word[pil_pkg::WORD_WIDTH-1:0];

  always_comb begin
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    do_replace = 1'b0;
    fill_count_next = fill_count;
    rsp_next = '0;
    rsp_next.status = pil_pkg::ST_OK;
    case (req.req_type)
      pil_pkg::REQ_INSERT: begin
        if (is_full_now) begin
          rsp_next.status = pil_pkg::ST_FULL;
        end else if (!ins_pos_ok) begin
          rsp_next.status = pil_pkg::ST_BADPOS;
        end else begin
          do_insert = accept;
          fill_count_next = fill_count + pil_pkg::FILL_W'(1);
        end
      end
      pil_pkg::REQ_DELETE: begin
        if (fill_count == '0) begin
          rsp_next.status = pil_pkg::ST_EMPTY;
        end else if (!pos_ok) begin
          rsp_next.status = pil_pkg::ST_BADPOS;
        end else begin
          do_delete = accept;
          rsp_next.read_word = pil_pkg::DATA_W'(sel_word);
          fill_count_next = fill_count - pil_pkg::FILL_W'(1);
        end
      end
      pil_pkg::REQ_RETRIEVE: begin
        if (!pos_ok) begin
          rsp_next.status = pil_pkg::ST_BADPOS;
        end else begin
          rsp_next.read_word = pil_pkg::DATA_W'(sel_word);
        end
      end
      pil_pkg::REQ_REPLACE: begin
        if (!pos_ok) begin
          rsp_next.status = pil_pkg::ST_BADPOS;
        end else begin
          do_replace = accept;
        end
      end
      pil_pkg::REQ_CLEAR: begin
        fill_count_next = '0;
      end
      default: begin
        fill_count_next = fill_count;
      end
    endcase
    rsp_next.item_count = pil_pkg::CNT_W'(fill_count_next);
    rsp_next.is_full    = (fill_count_next == pil_pkg::FILL_W'(pil_pkg::DEPTH));
    rsp_next.is_empty   = (fill_count_next == '0);
  end

  for (genvar i = 0; i < pil_pkg::DEPTH; i++) begin : g_cell
    pil_pkg::cell_cmd_t             cmd;
    logic [pil_pkg::WORD_WIDTH-1:0] low_word;
    logic [pil_pkg::WORD_WIDTH-1:0] high_word;

    if (i == 0) begin : g_first
      assign low_word = '0;
    end else begin : g_mid_low
      assign low_word = cell_word[i-1];
    end
    if (i == pil_pkg::DEPTH - 1) begin : g_last
      assign high_word = '0;
    end else begin : g_mid_high
      assign high_word = cell_word[i+1];
    end

    always_comb begin
      cmd.op        = pil_pkg::CELL_HOLD;
      cmd.load_word = wword;
      if (do_insert) begin
        if (pil_pkg::IDX_W'(i) == idx) begin
          cmd.op = pil_pkg::CELL_LOAD;
        end else if (pil_pkg::IDX_W'(i) > idx) begin
          cmd.op = pil_pkg::CELL_FROM_LOW;
        end
      end else if (do_delete) begin
        if ((pil_pkg::IDX_W'(i) >= idx) && (i < pil_pkg::DEPTH - 1)) begin
          cmd.op = pil_pkg::CELL_FROM_HIGH;
        end
      end else if (do_replace) begin
        if (pil_pkg::IDX_W'(i) == idx) begin
          cmd.op = pil_pkg::CELL_LOAD;
        end
      end
    end

    pil_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .low_word  (low_word),
      .high_word (high_word),
      .word      (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        fill_count <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= pil_pkg::FILL_W'(pil_pkg::DEPTH))
    else $error("fill count above depth");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (pil_pkg::FILL_W'(rsp.item_count) == fill_count))
    else $error("reported count differs from stored count");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == pil_pkg::REQ_INSERT && is_full_now)
    |=> (done && rsp.status == pil_pkg::ST_FULL && $stable(fill_count)))
    else $error("insert into full list not rejected");

  a_error_no_change: assert property (@(posedge clk) disable iff (rst)
    (accept && rsp_next.status != pil_pkg::ST_OK) |=> $stable(fill_count))
    else $error("failed item changed the count");

  a_read_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != pil_pkg::ST_OK) |-> (rsp.read_word == '0))
    else $error("nonzero read word on error");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional insert/delete list. A driver sends
// request items in random bursts from a pending queue; a monitor keeps a
// shadow list, predicts each result when its item is taken and compares
// every field of each done-strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 600;

  typedef struct {
    pil_pkg::req_t r;
    bit            drain;   // wait for all results before sending this item
  } pend_item_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  pil_pkg::req_t  req = '0;
  logic           busy;
  logic           done;
  pil_pkg::rsp_t  rsp;

  pend_item_t    req_pending[$];
  pil_pkg::rsp_t rsp_expected[$];

  logic [pil_pkg::WORD_WIDTH-1:0] list_words [pil_pkg::DEPTH];
  int list_len = 0;
  int gen_len = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  logic item_taken = 1'b0;

  positional_insert_delete_list_top dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow list: applies one request and returns the result it should give.
  function automatic pil_pkg::rsp_t list_apply(pil_pkg::req_t r);
    pil_pkg::rsp_t    o;
    logic [31:0]      got_word;
    pil_pkg::status_t st;
    int               p;
    got_word = '0;
    st = pil_pkg::ST_OK;
    p = r.position;
    case (pil_pkg::req_kind_t'(r.req_type))
      pil_pkg::REQ_INSERT: begin
        if (list_len >= pil_pkg::DEPTH) st = pil_pkg::ST_FULL;
        else if (p < 1 || p > list_len + 1) st = pil_pkg::ST_BADPOS;
        else begin
          for (int i = list_len; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = r.write_word[pil_pkg::WORD_WIDTH-1:0];
          list_len++;
        end
      end
      pil_pkg::REQ_DELETE: begin
        if (list_len == 0) st = pil_pkg::ST_EMPTY;
        else if (p < 1 || p > list_len) st = pil_pkg::ST_BADPOS;
        else begin
          got_word = list_words[p-1];
          for (int i = p; i < list_len; i++) list_words[i-1] = list_words[i];
          list_len--;
        end
      end
      pil_pkg::REQ_RETRIEVE: begin
        if (p < 1 || p > list_len) st = pil_pkg::ST_BADPOS;
        else got_word = list_words[p-1];
      end
      pil_pkg::REQ_REPLACE: begin
        if (p < 1 || p > list_len) st = pil_pkg::ST_BADPOS;
        else list_words[p-1] = r.write_word[pil_pkg::WORD_WIDTH-1:0];
      end
      pil_pkg::REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    o.read_word  = got_word;
    o.status     = st;
    o.item_count = pil_pkg::CNT_W'(list_len);
    o.is_full    = (list_len == pil_pkg::DEPTH);
    o.is_empty   = (list_len == 0);
    return o;
  endfunction

  // Queues one item and tracks the list length it leaves behind.
  task automatic push_req(input logic [pil_pkg::REQ_W-1:0] code, input int pos,
                          input logic [31:0] word, input bit drain = 1'b0);
    pend_item_t p;
    p.r.req_type   = code;
    p.r.position   = pos[pil_pkg::POS_W-1:0];
    p.r.write_word = word;
    p.drain        = drain;
    req_pending.push_back(p);
    case (code)
      pil_pkg::REQ_INSERT:
        if (gen_len < pil_pkg::DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
      pil_pkg::REQ_DELETE:
        if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      pil_pkg::REQ_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  // Mostly legal positions in 1..hi, with edges and out-of-range values mixed in.
  function automatic int pick_pos(int hi);
    int r;
    r = $urandom_range(0, 19);
    if (hi < 1) hi = 1;
    if (r == 0) return $urandom_range(0, 31);
    if (r == 1) return 0;
    if (r == 2) return (hi + 1 > 31) ? 31 : hi + 1;
    if (r == 3) return hi;
    if (r == 4) return 1;
    return $urandom_range(1, hi);
  endfunction

  task automatic report_field(input string fname, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, fname,
               want_v, got_v);
      err_count++;
    end
  endtask

  // Driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // item still waiting to be taken
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (req_pending.size() == 0 ||
                 (req_pending[0].drain && rsp_expected.size() != 0)) begin
      start <= 1'b0;
    end else begin
      req <= req_pending[0].r;
      req_pending.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0:       gap_left <= 0;
          1, 2:    gap_left <= $urandom_range(1, 5);
          default: gap_left <= $urandom_range(6, 20);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin : mon
    pil_pkg::rsp_t want;
    if (rst) begin
      item_taken <= 1'b0;
      idle_cycles <= 0;
      list_len = 0;
    end else begin
      if (done) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $realtime, rsp);
          err_count++;
        end else begin
          want = rsp_expected.pop_front();
          report_field("read_word", want.read_word, rsp.read_word);
          report_field("status", 32'(want.status), 32'(rsp.status));
          report_field("item_count", 32'(want.item_count), 32'(rsp.item_count));
          report_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
          report_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
        end
      end
      if (start && !busy) rsp_expected.push_back(list_apply(req));
      item_taken <= start && !busy;
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no activity", $realtime);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n_items;
    int seg;
    int mode;
    int roll;
    bit drain;
    logic [pil_pkg::REQ_W-1:0] code;
    int pos;

    // directed: empty-list errors, edges of position and word, every code
    push_req(pil_pkg::REQ_RETRIEVE, 1, 32'h0);
    push_req(pil_pkg::REQ_REPLACE, 1, 32'h1234_5678);
    push_req(pil_pkg::REQ_DELETE, 1, 32'h0);
    push_req(pil_pkg::REQ_DELETE, 0, 32'h0);
    push_req(pil_pkg::REQ_INSERT, 0, 32'hDEAD_BEEF);
    push_req(pil_pkg::REQ_INSERT, 2, 32'hDEAD_BEEF);
    push_req(pil_pkg::REQ_INSERT, 1, 32'hFFFF_FFFF);
    push_req(pil_pkg::REQ_INSERT, 1, 32'h0000_0000);
    push_req(pil_pkg::REQ_INSERT, 3, 32'hA5A5_A5A5);
    push_req(pil_pkg::REQ_INSERT, 5, 32'h1);
    push_req(pil_pkg::REQ_INSERT, 31, 32'h2);
    push_req(pil_pkg::REQ_RETRIEVE, 1, 32'h0);
    push_req(pil_pkg::REQ_RETRIEVE, 3, 32'hFFFF_FFFF);
    push_req(pil_pkg::REQ_RETRIEVE, 4, 32'h0);
    push_req(pil_pkg::REQ_REPLACE, 2, 32'h5A5A_5A5A);
    push_req(pil_pkg::REQ_RETRIEVE, 2, 32'h0);
    push_req(pil_pkg::REQ_DELETE, 0, 32'h0);
    push_req(pil_pkg::REQ_DELETE, 31, 32'h0);
    push_req(pil_pkg::REQ_DELETE, 2, 32'h0);
    push_req(3'd5, 1, 32'hFFFF_FFFF);
    push_req(3'd6, 31, 32'h0);
    push_req(3'd7, 2, 32'h8000_0001);
    push_req(pil_pkg::REQ_CLEAR, 0, 32'h0);
    push_req(pil_pkg::REQ_RETRIEVE, 1, 32'h0);
    push_req(pil_pkg::REQ_DELETE, 1, 32'h0, 1'b1);

    // random: fill to full first, then growing, shrinking and mixed stretches
    n_items = 0;
    while (gen_len < pil_pkg::DEPTH) begin
      push_req(pil_pkg::REQ_INSERT, $urandom_range(1, gen_len + 1), $urandom);
      n_items++;
    end
    push_req(pil_pkg::REQ_INSERT, 0, $urandom);
    push_req(pil_pkg::REQ_INSERT, $urandom_range(1, 31), $urandom);
    push_req(pil_pkg::REQ_DELETE, pil_pkg::DEPTH, 32'h0, 1'b1);
    n_items += 3;
    while (n_items < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      seg = $urandom_range(8, 40);
      drain = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < seg; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) code = pil_pkg::REQ_CLEAR;
        else if (roll < 4) code = pil_pkg::REQ_W'($urandom_range(5, 7));
        else begin
          roll = $urandom_range(0, 99);
          case (mode)
            0: code = (roll < 70) ? pil_pkg::REQ_INSERT :
                      (roll < 80) ? pil_pkg::REQ_DELETE :
                      (roll < 90) ? pil_pkg::REQ_RETRIEVE : pil_pkg::REQ_REPLACE;
            1: code = (roll < 70) ? pil_pkg::REQ_DELETE :
                      (roll < 80) ? pil_pkg::REQ_INSERT :
                      (roll < 90) ? pil_pkg::REQ_RETRIEVE : pil_pkg::REQ_REPLACE;
            default: code = (roll < 25) ? pil_pkg::REQ_INSERT :
                            (roll < 50) ? pil_pkg::REQ_DELETE :
                            (roll < 75) ? pil_pkg::REQ_RETRIEVE : pil_pkg::REQ_REPLACE;
          endcase
        end
        pos = (code == pil_pkg::REQ_INSERT) ? pick_pos(gen_len + 1) : pick_pos(gen_len);
        push_req(code, pos, $urandom, drain && k == 0);
      end
      n_items += seg;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (req_pending.size() == 0);
    @(posedge clk);
    while (start || rsp_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pil_pkg.sv
rtl/pil_cell.sv
rtl/positional_insert_delete_list_top.sv
tb/tb.sv
